// ===== rtl/periodic_pair_distance_assert.svh =====
// Assertion macros used by the RTL.
`ifndef PERIODIC_PAIR_DISTANCE_ASSERT_SVH
`define PERIODIC_PAIR_DISTANCE_ASSERT_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define PPD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define PPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ppd_pkg.sv =====
`default_nettype none

package ppd_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int IDX_W       = $clog2(MAX_POINTS);
   localparam int COORD_W     = 28;
   localparam int EDGE_W      = 27;
   localparam int COUNT_W     = 7;
   localparam int DIST_W      = 30;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int MAG_W       = COORD_W + 1;
   localparam int SUM_W       = 2 * COORD_W + 2;
   localparam int ROOT_W      = SUM_W / 2;
   localparam int REM_W       = ROOT_W + 2;
   localparam int POS_W       = 3 * COORD_W;
   localparam int PRE_STAGES  = 5;
   localparam int NUM_STAGES  = PRE_STAGES + ROOT_W;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [EDGE_W-1:0]  EDGE_RESET  = EDGE_W'(65536);
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_POINTS);

   typedef enum logic {
      REG_BOX_EDGE    = 1'b0,
      REG_POINT_COUNT = 1'b1
   } reg_sel_type;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_ROW  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ORIGIN,
      ST_OWAIT,
      ST_ROW
   } state_type;

   // Tag that travels with each beat down the pipeline
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             last;
   } meta_type;

endpackage

`default_nettype wire

// ===== rtl/periodic_pair_distance.sv =====
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | req_type, req_point_index, req_pos_x/y/z
// rsp     | out       | rsp_valid/rsp_stall  | rsp_distance, rsp_other_index, rsp_last_of_row
// csr     | in        | psel/penable/pready  | paddr, pwdata, pwrite, prdata
//
// A row first fetches the origin from the point memory (ST_ORIGIN, ST_OWAIT), then steps
// through indices 0..count-1, skipping the origin, through the single read port, one per
// cycle unless rsp stalls; results pass through the pipeline (5 pre stages, 29 root stages).
// Synchronous reset clears control and valid tags and presets the CSRs; the memory is not cleared.
// A stall on rsp with rsp_valid high freezes the pipeline and index issue (not ST_OWAIT).
`default_nettype none

module periodic_pair_distance
   import ppd_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire                       req_type,
   input  wire        [IDX_W-1:0]    req_point_index,
   input  wire signed [COORD_W-1:0]  req_pos_x,
   input  wire signed [COORD_W-1:0]  req_pos_y,
   input  wire signed [COORD_W-1:0]  req_pos_z,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic       [DIST_W-1:0]   rsp_distance,
   output logic       [IDX_W-1:0]    rsp_other_index,
   output logic                      rsp_last_of_row,
   input  wire                       psel,
   input  wire                       penable,
   input  wire                       pwrite,
   input  wire        [ADDR_W-1:0]   paddr,
   input  wire        [DATA_W-1:0]   pwdata,
   output logic       [DATA_W-1:0]   prdata,
   output logic                      pready
);

`include "periodic_pair_distance_assert.svh"

   // Configuration
   logic [EDGE_W-1:0]  box_edge_ff;
   logic [COUNT_W-1:0] point_count_ff;
   reg_sel_type        reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = reg_sel_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         box_edge_ff    <= EDGE_RESET;
         point_count_ff <= COUNT_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (reg_sel)
            REG_BOX_EDGE:    box_edge_ff    <= pwdata[EDGE_W-1:0];
            REG_POINT_COUNT: point_count_ff <= pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_BOX_EDGE:    prdata = DATA_W'(box_edge_ff);
         REG_POINT_COUNT: prdata = DATA_W'(point_count_ff);
         default:         prdata = '0;
      endcase
   end

   // Sequencer
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   origin_idx_ff, origin_idx_in;
   logic [IDX_W-1:0]   last_j_ff, last_j_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [POS_W-1:0]   origin_pos_ff, origin_pos_in;
   logic [COUNT_W-1:0] count_eff;
   logic               req_accept;
   logic               row_ok;
   logic               adv;
   logic               issue;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [POS_W-1:0]   rd_data_ff;
   logic [POS_W-1:0]   pos_mem [MAX_POINTS];
   meta_type           meta_ff [NUM_STAGES];

   assign adv        = !(meta_ff[NUM_STAGES-1].valid && rsp_stall);
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign count_eff  = (point_count_ff > COUNT_MAX) ? COUNT_MAX : point_count_ff;
   assign row_ok     = ({1'b0, req_point_index} < count_eff) && (count_eff >= COUNT_W'(2));

   always_comb begin
      state_in      = state_ff;
      origin_idx_in = origin_idx_ff;
      last_j_in     = last_j_ff;
      j_in          = j_ff;
      origin_pos_in = origin_pos_ff;
      issue         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = j_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_kind_type'(req_type) == REQ_ROW) && row_ok) begin
               origin_idx_in = req_point_index;
               j_in          = '0;
               if ({1'b0, req_point_index} == count_eff - COUNT_W'(1))
                  last_j_in = IDX_W'(count_eff - COUNT_W'(2));
               else
                  last_j_in = IDX_W'(count_eff - COUNT_W'(1));
               state_in = ST_ORIGIN;
            end
         end
         ST_ORIGIN: begin
            rd_en   = 1'b1;
            rd_addr = origin_idx_ff;
            if (adv)
               state_in = ST_OWAIT;
         end
         ST_OWAIT: begin
            origin_pos_in = rd_data_ff;
            state_in      = ST_ROW;
         end
         ST_ROW: begin
            if (j_ff == origin_idx_ff) begin
               j_in = j_ff + IDX_W'(1);
            end else begin
               issue = 1'b1;
               rd_en = 1'b1;
               if (adv) begin
                  if (j_ff == last_j_ff)
                     state_in = ST_IDLE;
                  else
                     j_in = j_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      origin_idx_ff <= origin_idx_in;
      last_j_ff     <= last_j_in;
      j_ff          <= j_in;
      origin_pos_ff <= origin_pos_in;
   end

   // Point memory: one write port for loads, one registered read port
   always_ff @(posedge clock) begin
      if (req_accept && (req_kind_type'(req_type) == REQ_LOAD))
         pos_mem[req_point_index] <= {req_pos_x, req_pos_y, req_pos_z};
      if (adv && rd_en)
         rd_data_ff <= pos_mem[rd_addr];
   end

   // Tag shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STAGES; s++)
            meta_ff[s] <= '0;
      end else if (adv) begin
         meta_ff[0] <= '{valid: issue, idx: j_ff, last: (j_ff == last_j_ff)};
         for (int s = 1; s < NUM_STAGES; s++)
            meta_ff[s] <= meta_ff[s-1];
      end
   end

   // Per-axis difference, minimum-image wrap, square, sum
   logic signed [DIFF_W-1:0] diff_ff [3];
   logic        [MAG_W-1:0]  mag_ff  [3];
   logic        [SUM_W-3:0]  sqr_ff  [3];
   logic        [SUM_W-1:0]  sum_ff;
   logic signed [DIFF_W-1:0] diff_in [3];
   logic        [MAG_W-1:0]  mag_in  [3];

   always_comb begin
      logic signed [COORD_W-1:0] a;
      logic signed [COORD_W-1:0] b;
      logic        [MAG_W-1:0]   m;
      logic signed [DIFF_W:0]    w;
      for (int k = 0; k < 3; k++) begin
         b = rd_data_ff[(2-k)*COORD_W +: COORD_W];
         a = origin_pos_ff[(2-k)*COORD_W +: COORD_W];
         diff_in[k] = DIFF_W'(b) - DIFF_W'(a);
         // wrap once by the box edge when twice the magnitude exceeds it
         m = diff_ff[k][DIFF_W-1] ? MAG_W'(-diff_ff[k]) : MAG_W'(diff_ff[k]);
         w = (DIFF_W+1)'(diff_ff[k]);
         if ({m, 1'b0} > (MAG_W+1)'(box_edge_ff)) begin
            if (diff_ff[k][DIFF_W-1])
               w = w + (DIFF_W+1)'(box_edge_ff);
            else
               w = w - (DIFF_W+1)'(box_edge_ff);
         end
         mag_in[k] = w[DIFF_W] ? MAG_W'(-w) : MAG_W'(w);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            diff_ff[k] <= diff_in[k];
            mag_ff[k]  <= mag_in[k];
            sqr_ff[k]  <= (SUM_W-2)'(mag_ff[k]) * (SUM_W-2)'(mag_ff[k]);
         end
         sum_ff <= SUM_W'(sqr_ff[0]) + SUM_W'(sqr_ff[1]) + SUM_W'(sqr_ff[2]);
      end
   end

   // Integer square root, one result bit per stage
   logic [SUM_W-1:0]  sq_rad_ff  [ROOT_W];
   logic [REM_W-1:0]  sq_rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] sq_root_ff [ROOT_W];
   logic [SUM_W-1:0]  sq_rad_in  [ROOT_W];
   logic [REM_W-1:0]  sq_rem_in  [ROOT_W];
   logic [ROOT_W-1:0] sq_root_in [ROOT_W];
   logic [SUM_W-1:0]  src_rad    [ROOT_W];
   logic [REM_W-1:0]  src_rem    [ROOT_W];
   logic [ROOT_W-1:0] src_root   [ROOT_W];

   always_comb begin
      logic [REM_W+1:0] acc;
      logic [REM_W+1:0] trial;
      src_rad[0]  = sum_ff;
      src_rem[0]  = '0;
      src_root[0] = '0;
      for (int k = 1; k < ROOT_W; k++) begin
         src_rad[k]  = sq_rad_ff[k-1];
         src_rem[k]  = sq_rem_ff[k-1];
         src_root[k] = sq_root_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         acc   = {src_rem[k], src_rad[k][SUM_W-1 -: 2]};
         trial = (REM_W+2)'({src_root[k], 2'b01});
         if (acc >= trial) begin
            sq_rem_in[k]  = REM_W'(acc - trial);
            sq_root_in[k] = {src_root[k][ROOT_W-2:0], 1'b1};
         end else begin
            sq_rem_in[k]  = acc[REM_W-1:0];
            sq_root_in[k] = {src_root[k][ROOT_W-2:0], 1'b0};
         end
         sq_rad_in[k] = {src_rad[k][SUM_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < ROOT_W; k++) begin
            sq_rad_ff[k]  <= sq_rad_in[k];
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
         end
      end
   end

   // Output beat
   assign rsp_valid       = meta_ff[NUM_STAGES-1].valid;
   assign rsp_other_index = meta_ff[NUM_STAGES-1].idx;
   assign rsp_last_of_row = meta_ff[NUM_STAGES-1].last;
   assign rsp_distance    = DIST_W'(sq_root_ff[ROOT_W-1]);

   // Checks
   `PPD_ASSERT_NOW(a_no_self, clock, reset, issue, j_ff != origin_idx_ff, "row issued its own origin")
   `PPD_ASSERT_NEXT(a_row_ends, clock, reset, issue && adv && (j_ff == last_j_ff), state_ff == ST_IDLE, "row did not end after last index")
   `PPD_ASSERT_NEXT(a_freeze, clock, reset, rsp_valid && rsp_stall, $stable(meta_ff[NUM_STAGES-2]), "pipeline moved under stall")

endmodule

`default_nettype wire

// ===== verif/periodic_pair_distance_tb.sv =====
`default_nettype none

module periodic_pair_distance_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import ppd_pkg::*;

   typedef struct {
      req_kind_type            kind;
      logic [IDX_W-1:0]        idx;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] pz;
   } point_req_type;

   typedef struct {
      logic [DIST_W-1:0] dist_val;
      logic [IDX_W-1:0]  other;
      logic              last;
   } dist_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_type = 1'b0;
   logic [IDX_W-1:0]          req_point_index = '0;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_y = '0;
   logic signed [COORD_W-1:0] req_pos_z = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [DIST_W-1:0]         rsp_distance;
   logic [IDX_W-1:0]          rsp_other_index;
   logic                      rsp_last_of_row;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [ADDR_W-1:0]         paddr = '0;
   logic [DATA_W-1:0]         pwdata = '0;
   logic [DATA_W-1:0]         prdata;
   logic                      pready;

   periodic_pair_distance i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_point_index(req_point_index),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_distance(rsp_distance),
      .rsp_other_index(rsp_other_index), .rsp_last_of_row(rsp_last_of_row),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow of the block's state
   logic [EDGE_W-1:0]  edge_len = EDGE_RESET;
   logic [COUNT_W-1:0] pts_used = COUNT_RESET;
   logic signed [COORD_W-1:0] xs [MAX_POINTS];
   logic signed [COORD_W-1:0] ys [MAX_POINTS];
   logic signed [COORD_W-1:0] zs [MAX_POINTS];

   point_req_type pending_reqs[$];
   dist_beat_type expected_dists[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int rows_sent = 0;

   // Minimum-image magnitude of b - a on one axis
   function automatic longint unsigned axis_mag(longint b, longint a);
      longint d;
      longint unsigned m;
      d = b - a;
      m = (d < 0) ? -d : d;
      if (2 * m > edge_len) d = (d > 0) ? d - edge_len : d + edge_len;
      return (d < 0) ? -d : d;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Apply one accepted beat to the shadow and queue the row it produces
   function automatic void predict_row(point_req_type q);
      int n;
      longint unsigned ax, ay, az;
      dist_beat_type e;
      if (q.kind == REQ_LOAD) begin
         xs[q.idx] = q.px;
         ys[q.idx] = q.py;
         zs[q.idx] = q.pz;
         return;
      end
      n = (pts_used > MAX_POINTS) ? MAX_POINTS : pts_used;
      if (q.idx >= n) return;
      for (int j = 0; j < n; j++) begin
         if (j == q.idx) continue;
         ax = axis_mag(xs[j], xs[q.idx]);
         ay = axis_mag(ys[j], ys[q.idx]);
         az = axis_mag(zs[j], zs[q.idx]);
         e.dist_val = DIST_W'(int_sqrt(ax * ax + ay * ay + az * az));
         e.other = IDX_W'(j);
         e.last = 1'b0;
         expected_dists = {expected_dists, e};
      end
      if (n > 1) expected_dists[$].last = 1'b1;
   endfunction

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            point_req_type q;
            q = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_type <= q.kind;
            req_point_index <= q.idx;
            req_pos_x <= q.px;
            req_pos_y <= q.py;
            req_pos_z <= q.pz;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Input-side prediction on accepted beats
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         point_req_type q;
         q.kind = req_kind_type'(req_type);
         q.idx = req_point_index;
         q.px = req_pos_x;
         q.py = req_pos_y;
         q.pz = req_pos_z;
         predict_row(q);
      end
   end

   // Receiver stall, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         dist_beat_type e;
         if (expected_dists.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: dist %0d other %0d last %0d",
                        rsp_distance, rsp_other_index, rsp_last_of_row);
         end else begin
            e = expected_dists.pop_front();
            if (e.dist_val !== rsp_distance || e.other !== rsp_other_index ||
                e.last !== rsp_last_of_row) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp dist %0d other %0d last %0d, got %0d %0d %0d",
                           e.dist_val, e.other, e.last,
                           rsp_distance, rsp_other_index, rsp_last_of_row);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat while work is outstanding
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (pending_reqs.size() == 0 && expected_dists.size() == 0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic csr_write(reg_sel_type sel, logic [DATA_W-1:0] val);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ADDR_W'(4 * int'(sel));
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (sel == REG_BOX_EDGE) edge_len = val[EDGE_W-1:0];
      else pts_used = val[COUNT_W-1:0];
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_dists.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord(int spread);
      case ($urandom_range(3))
         0: return COORD_W'($urandom);
         default: return COORD_W'(int'($urandom_range(2 * spread)) - spread);
      endcase
   endfunction

   task automatic push_load(int idx, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
      point_req_type q;
      q.kind = REQ_LOAD;
      q.idx = IDX_W'(idx);
      q.px = x;
      q.py = y;
      q.pz = z;
      pending_reqs = {pending_reqs, q};
   endtask

   task automatic push_row(int idx);
      point_req_type q;
      q.kind = REQ_ROW;
      q.idx = IDX_W'(idx);
      q.px = COORD_W'($urandom);
      q.py = COORD_W'($urandom);
      q.pz = COORD_W'($urandom);
      pending_reqs = {pending_reqs, q};
   endtask

   // Load every slot so no row ever reads an unwritten entry
   task automatic fill_all(int spread);
      for (int i = 0; i < MAX_POINTS; i++)
         push_load(i, rand_coord(spread), rand_coord(spread), rand_coord(spread));
   endtask

   // Random phase: mostly rows, loads in between
   task automatic random_phase(int n_items, int spread);
      for (int k = 0; k < n_items; k++) begin
         if ($urandom_range(2) == 0)
            push_load($urandom_range(MAX_POINTS - 1), rand_coord(spread),
                      rand_coord(spread), rand_coord(spread));
         else
            push_row($urandom_range(MAX_POINTS - 1));
      end
   endtask

   localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: exact half edge, extremes, over-range origin and indices
      send_idle_pct = 30;
      recv_idle_pct = 67;
      csr_write(REG_BOX_EDGE, 32'd65536);
      csr_write(REG_POINT_COUNT, 32'd4);
      push_load(0, '0, '0, '0);
      push_load(1, COORD_W'(32768), COORD_W'(-32768), '0);
      push_load(2, COORD_W'(32769), '0, COORD_W'(-32769));
      push_load(3, CMAX, CMIN, CMAX);
      push_load(63, CMIN, CMAX, CMIN);
      push_row(0);
      push_row(3);
      push_row(4);
      push_row(63);
      wait_drained();

      csr_write(REG_BOX_EDGE, 32'd134217727);
      csr_write(REG_POINT_COUNT, 32'd2);
      push_row(0);
      push_row(1);
      push_load(1, CMIN, CMIN, CMIN);
      push_row(0);
      wait_drained();

      csr_write(REG_BOX_EDGE, 32'd1);
      csr_write(REG_POINT_COUNT, 32'd64);
      fill_all(1 << 20);
      push_row(63);
      push_row(0);
      wait_drained();

      // Random, receiver mostly idle; a long hold-off backs the block up
      csr_write(REG_BOX_EDGE, 32'd655360);
      csr_write(REG_POINT_COUNT, 32'd6);
      random_phase(40, 1 << 19);
      hold_cycles = 400;
      wait_drained();

      // Random, sender mostly idle
      send_idle_pct = 67;
      recv_idle_pct = 30;
      csr_write(REG_BOX_EDGE, 32'($urandom_range(134217727, 1)));
      csr_write(REG_POINT_COUNT, 32'($urandom_range(8, 2)));
      random_phase(40, 1 << 26);
      wait_drained();

      // Random, no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(REG_BOX_EDGE, 32'd3276800);
      csr_write(REG_POINT_COUNT, 32'd64);
      random_phase(6, 1 << 22);
      wait_drained();
      csr_write(REG_POINT_COUNT, 32'd5);
      random_phase(40, 1 << 22);
      wait_drained();

      if (mismatches == 0 && expected_dists.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
